// ===== hw/rtl/scc_pkg.sv =====
// ============================================================================
// scc_pkg
// Widths and inter-stage bundles for the swept circle collision pipeline.
// ============================================================================
package scc_pkg;

    localparam int COORD_BITS = 24;
    localparam int RAD_W      = 16;
    localparam int T_W        = 16;
    localparam int D_W        = COORD_BITS + 1;       // coordinate differences
    localparam int G_W        = RAD_W + 1;            // radius sum
    localparam int SQ_W       = 2 * COORD_BITS + 2;   // dot products and their magnitudes
    localparam int H_W        = SQ_W / 2;             // half of a dot product word
    localparam int S_W        = SQ_W + 1;             // signed cross dot product
    localparam int NN_W       = 2 * SQ_W;             // n*n and a*e
    localparam int AT_W       = SQ_W + T_W;           // a*T and n*T
    localparam int AH_W       = AT_W / 2;             // half of a*T
    localparam int ATP_W      = AH_W + T_W;           // partial of a*T*T
    localparam int ATT_W      = AT_W + T_W;           // a*T*T
    localparam int CMP_W      = ATT_W + 1;            // final comparison width
    localparam int LAT        = 7;                    // accept edge to result sample

    typedef struct packed {
        logic              over;   // already overlapping
        logic              azero;  // no relative motion
        logic              sneg;   // closing in
        logic [SQ_W-1:0]   e;
        logic [SQ_W-1:0]   a;
        logic [SQ_W-1:0]   n;
        logic [T_W-1:0]    t;
    } t_prep;

    typedef struct packed {
        logic              over;
        logic              azero;
        logic              sneg;
        logic [SQ_W-1:0]   e;
        logic [SQ_W-1:0]   n;
        logic [T_W-1:0]    t;
        logic [NN_W-1:0]   nn;
        logic [NN_W-1:0]   ae;
        logic [AT_W-1:0]   at;
        logic [AT_W-1:0]   nt;
    } t_mult;

endpackage

// ===== hw/rtl/scc_prep.sv =====
// ============================================================================
// scc_prep
// Relative motion, squared terms and dot products: three register stages.
// ============================================================================
module scc_prep (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [scc_pkg::RAD_W-1:0]           i_radius_a,
    input  logic signed [scc_pkg::COORD_BITS-1:0] i_pos_a_x,
    input  logic signed [scc_pkg::COORD_BITS-1:0] i_pos_a_y,
    input  logic signed [scc_pkg::COORD_BITS-1:0] i_vel_a_x,
    input  logic signed [scc_pkg::COORD_BITS-1:0] i_vel_a_y,
    input  logic [scc_pkg::RAD_W-1:0]           i_radius_b,
    input  logic signed [scc_pkg::COORD_BITS-1:0] i_pos_b_x,
    input  logic signed [scc_pkg::COORD_BITS-1:0] i_pos_b_y,
    input  logic signed [scc_pkg::COORD_BITS-1:0] i_vel_b_x,
    input  logic signed [scc_pkg::COORD_BITS-1:0] i_vel_b_y,
    input  logic [scc_pkg::T_W-1:0]             i_elapsed_ms,
    output logic                                o_valid,
    output scc_pkg::t_prep                      o_data
);

    // Stage 1: differences.
    logic                              r_v1;
    logic signed [scc_pkg::D_W-1:0]    r_dx, r_dy, r_vx, r_vy;
    logic [scc_pkg::G_W-1:0]           r_g1;
    logic [scc_pkg::T_W-1:0]           r_t1;

    // Stage 2: products.
    logic                              r_v2;
    logic signed [scc_pkg::SQ_W-1:0]   r_pxx, r_pyy, r_qxx, r_qyy, r_pxv, r_pyv;
    logic [2*scc_pkg::G_W-1:0]         r_gg;
    logic [scc_pkg::T_W-1:0]           r_t2;

    // Stage 3: sums.
    logic                              r_v3;
    scc_pkg::t_prep                    r_d3;

    logic [scc_pkg::SQ_W-1:0]          dd, aa, gg;
    logic signed [scc_pkg::S_W-1:0]    ss;
    logic [scc_pkg::S_W-1:0]           ns;

    always_comb begin
        dd = scc_pkg::SQ_W'(r_pxx) + scc_pkg::SQ_W'(r_pyy);
        aa = scc_pkg::SQ_W'(r_qxx) + scc_pkg::SQ_W'(r_qyy);
        gg = scc_pkg::SQ_W'(r_gg);
        ss = scc_pkg::S_W'(r_pxv) + scc_pkg::S_W'(r_pyv);
        ns = scc_pkg::S_W'(-ss);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx <= scc_pkg::D_W'(i_pos_a_x) - scc_pkg::D_W'(i_pos_b_x);
        r_dy <= scc_pkg::D_W'(i_pos_a_y) - scc_pkg::D_W'(i_pos_b_y);
        r_vx <= scc_pkg::D_W'(i_vel_a_x) - scc_pkg::D_W'(i_vel_b_x);
        r_vy <= scc_pkg::D_W'(i_vel_a_y) - scc_pkg::D_W'(i_vel_b_y);
        r_g1 <= scc_pkg::G_W'(i_radius_a) + scc_pkg::G_W'(i_radius_b);
        r_t1 <= i_elapsed_ms;

        r_pxx <= r_dx * r_dx;
        r_pyy <= r_dy * r_dy;
        r_qxx <= r_vx * r_vx;
        r_qyy <= r_vy * r_vy;
        r_pxv <= r_dx * r_vx;
        r_pyv <= r_dy * r_vy;
        r_gg  <= r_g1 * r_g1;
        r_t2  <= r_t1;

        r_d3.over  <= (dd <= gg);
        r_d3.azero <= (aa == '0);
        r_d3.sneg  <= ss[scc_pkg::S_W-1];
        r_d3.e     <= dd - gg;
        r_d3.a     <= aa;
        r_d3.n     <= ns[scc_pkg::SQ_W-1:0];
        r_d3.t     <= r_t2;
    end

    assign o_valid = r_v3;
    assign o_data  = r_d3;

endmodule

// ===== hw/rtl/scc_mult.sv =====
// ============================================================================
// scc_mult
// Wide products n*n, a*e, a*T and n*T from half-word partial products.
// ============================================================================
module scc_mult (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  scc_pkg::t_prep  i_data,
    output logic            o_valid,
    output scc_pkg::t_mult  o_data
);

    localparam int H  = scc_pkg::H_W;
    localparam int HT = scc_pkg::H_W + scc_pkg::T_W;

    logic                       r_v4;
    scc_pkg::t_prep             r_d4;
    logic [2*H-1:0]             r_nhh, r_nhl, r_nll;
    logic [2*H-1:0]             r_ahh, r_ahl, r_alh, r_all;
    logic [HT-1:0]              r_ath, r_atl, r_nth, r_ntl;

    logic                       r_v5;
    scc_pkg::t_mult             r_d5;

    logic [H-1:0] nh, nl, ah, al, eh, el;

    always_comb begin
        nh = i_data.n[scc_pkg::SQ_W-1:H];
        nl = i_data.n[H-1:0];
        ah = i_data.a[scc_pkg::SQ_W-1:H];
        al = i_data.a[H-1:0];
        eh = i_data.e[scc_pkg::SQ_W-1:H];
        el = i_data.e[H-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v4 <= i_valid;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d4  <= i_data;
        r_nhh <= nh * nh;
        r_nhl <= nh * nl;
        r_nll <= nl * nl;
        r_ahh <= ah * eh;
        r_ahl <= ah * el;
        r_alh <= al * eh;
        r_all <= al * el;
        r_ath <= ah * i_data.t;
        r_atl <= al * i_data.t;
        r_nth <= nh * i_data.t;
        r_ntl <= nl * i_data.t;

        r_d5.over  <= r_d4.over;
        r_d5.azero <= r_d4.azero;
        r_d5.sneg  <= r_d4.sneg;
        r_d5.e     <= r_d4.e;
        r_d5.n     <= r_d4.n;
        r_d5.t     <= r_d4.t;
        r_d5.nn    <= (scc_pkg::NN_W'(r_nhh) << (2 * H))
                    + (scc_pkg::NN_W'(r_nhl) << (H + 1))
                    + scc_pkg::NN_W'(r_nll);
        r_d5.ae    <= (scc_pkg::NN_W'(r_ahh) << (2 * H))
                    + ((scc_pkg::NN_W'(r_ahl) + scc_pkg::NN_W'(r_alh)) << H)
                    + scc_pkg::NN_W'(r_all);
        r_d5.at    <= (scc_pkg::AT_W'(r_ath) << H) + scc_pkg::AT_W'(r_atl);
        r_d5.nt    <= (scc_pkg::AT_W'(r_nth) << H) + scc_pkg::AT_W'(r_ntl);
    end

    assign o_valid = r_v5;
    assign o_data  = r_d5;

endmodule

// ===== hw/rtl/scc_decide.sv =====
// ============================================================================
// scc_decide
// Discriminant and window tests, then the registered verdict.
// ============================================================================
module scc_decide (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  scc_pkg::t_mult  i_data,
    output logic            o_strobe,
    output logic            o_collides
);

    localparam int AH = scc_pkg::AH_W;

    logic                          r_v6;
    logic                          r_over6, r_cand6, r_early6;
    logic [scc_pkg::SQ_W-1:0]      r_e6;
    logic [scc_pkg::AT_W-1:0]      r_nt6;
    logic [scc_pkg::ATP_W-1:0]     r_atth, r_attl;

    logic                          r_strobe, r_collides;

    logic [scc_pkg::CMP_W-1:0]     lhs, rhs;
    logic [scc_pkg::AT_W:0]        n256;

    always_comb begin
        n256 = ((scc_pkg::AT_W + 1)'(i_data.n) << 8);
        lhs  = (scc_pkg::CMP_W'(r_atth) << AH) + scc_pkg::CMP_W'(r_attl)
             + (scc_pkg::CMP_W'(r_e6) << 16);
        rhs  = scc_pkg::CMP_W'(r_nt6) << 9;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_v6     <= i_valid;
            r_strobe <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        r_over6  <= i_data.over;
        // A later touch needs motion, closing in and a real root.
        r_cand6  <= !i_data.azero && i_data.sneg && (i_data.nn >= i_data.ae);
        r_early6 <= (n256 < {1'b0, i_data.at});
        r_e6     <= i_data.e;
        r_nt6    <= i_data.nt;
        r_atth   <= i_data.at[scc_pkg::AT_W-1:AH] * i_data.t;
        r_attl   <= i_data.at[AH-1:0] * i_data.t;

        r_collides <= r_v6 && (r_over6 || (r_cand6 && (r_early6 || (lhs < rhs))));
    end

    assign o_strobe   = r_strobe;
    assign o_collides = r_collides;

endmodule

// ===== hw/rtl/swept_circle_collision_top.sv =====
// Path: a beat accepted at a clock edge is registered through the prep, mult and
// decide stages before its result is shown on o_strobe and o_collides.
// Throughput: one beat per cycle; busy is never raised, the pipeline has no stalls.
// Reset: synchronous, active low; clears the valid bits, drops beats in flight.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ============================================================================
// swept_circle_collision_top
// Exact fixed-point test of whether two moving circles touch within a window.
// ============================================================================
module swept_circle_collision_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [scc_pkg::RAD_W-1:0]             i_radius_a,
    input  logic signed [scc_pkg::COORD_BITS-1:0] i_pos_a_x,
    input  logic signed [scc_pkg::COORD_BITS-1:0] i_pos_a_y,
    input  logic signed [scc_pkg::COORD_BITS-1:0] i_vel_a_x,
    input  logic signed [scc_pkg::COORD_BITS-1:0] i_vel_a_y,
    input  logic [scc_pkg::RAD_W-1:0]             i_radius_b,
    input  logic signed [scc_pkg::COORD_BITS-1:0] i_pos_b_x,
    input  logic signed [scc_pkg::COORD_BITS-1:0] i_pos_b_y,
    input  logic signed [scc_pkg::COORD_BITS-1:0] i_vel_b_x,
    input  logic signed [scc_pkg::COORD_BITS-1:0] i_vel_b_y,
    input  logic [scc_pkg::T_W-1:0]               i_elapsed_ms,
    output logic                                  o_strobe,
    output logic                                  o_collides
);

    logic           prep_valid, mult_valid;
    scc_pkg::t_prep prep_data;
    scc_pkg::t_mult mult_data;

    assign busy = 1'b0;

    scc_prep u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (start && !busy),
        .i_radius_a   (i_radius_a),
        .i_pos_a_x    (i_pos_a_x),
        .i_pos_a_y    (i_pos_a_y),
        .i_vel_a_x    (i_vel_a_x),
        .i_vel_a_y    (i_vel_a_y),
        .i_radius_b   (i_radius_b),
        .i_pos_b_x    (i_pos_b_x),
        .i_pos_b_y    (i_pos_b_y),
        .i_vel_b_x    (i_vel_b_x),
        .i_vel_b_y    (i_vel_b_y),
        .i_elapsed_ms (i_elapsed_ms),
        .o_valid      (prep_valid),
        .o_data       (prep_data)
    );

    scc_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prep_valid),
        .i_data  (prep_data),
        .o_valid (mult_valid),
        .o_data  (mult_data)
    );

    scc_decide u_decide (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (mult_valid),
        .i_data     (mult_data),
        .o_strobe   (o_strobe),
        .o_collides (o_collides)
    );

`ifndef SYNTHESIS
    a_beat_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##7 o_strobe)
        else $error("accepted beat produced no result");
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, 7))
        else $error("result without an accepted beat");
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_strobe |-> !o_collides)
        else $error("collides raised without strobe");
    a_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (prep_valid && prep_data.over) |-> ##4 (o_strobe && o_collides))
        else $error("overlapping pair not reported");
`endif

endmodule
